// ----- rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define QTE_ASSERT_IMP(lbl, clk, rst, ant, con) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ant) |-> (con)) \
      else $error("assertion failed");

// next-cycle implication
`define QTE_ASSERT_NXT(lbl, clk, rst, ant, con) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ant) |=> (con)) \
      else $error("assertion failed");

`endif

// ----- rtl/qte_pkg.sv -----
// ----------------------------------------------------------------------------
// qte_pkg
// types, widths and constants of the quaternion to euler angle pipeline
// ----------------------------------------------------------------------------
package qte_pkg;

   localparam int CW = 16;   // normalised component width
   localparam int XW = 36;   // cordic x/y width
   localparam int ZW = 35;   // angle width, radians * 2^30
   localparam int RW = 62;   // square root radicand width
   localparam int SW = 31;   // square root result width

   localparam logic signed [ZW-1:0] ANG_PI      = 35'sd3373259426;
   localparam logic signed [ZW-1:0] ANG_HALF_PI = 35'sd1686629713;
   localparam logic [30:0]          DEG_SCALE   = 31'd1922527338;

   typedef enum logic [1:0] {
      PM_ATAN = 2'b00,
      PM_POS  = 2'b01,
      PM_NEG  = 2'b10
   } qte_pmode_type;

   typedef struct packed {
      qte_pmode_type mode;
      logic          clip;
   } qte_tag_type;

   typedef struct packed {
      logic signed [XW-1:0] x;
      logic signed [XW-1:0] y;
   } qte_vec_type;

   typedef struct packed {
      qte_vec_type  roll;
      qte_vec_type  yaw;
      logic [SW-1:0] ss;
      logic         neg;
      qte_tag_type  tag;
   } qte_pass_type;

   typedef struct packed {
      qte_vec_type          v;
      logic signed [ZW-1:0] z;
      logic                 zero;
      qte_tag_type          tag;
   } qte_cord_type;

   // atan(2^-i) * 2^30, truncated
   function automatic logic [29:0] atan_entry(input int i);
      logic [29:0] r;
      unique case (i)
         0:  r = 30'h3243F6A8;
         1:  r = 30'h1DAC6705;
         2:  r = 30'h0FADBAFC;
         3:  r = 30'h07F56EA6;
         4:  r = 30'h03FEAB76;
         5:  r = 30'h01FFD55B;
         6:  r = 30'h00FFFAAA;
         7:  r = 30'h007FFF55;
         8:  r = 30'h003FFFEA;
         9:  r = 30'h001FFFFD;
         10: r = 30'h000FFFFF;
         11: r = 30'h0007FFFF;
         12: r = 30'h0003FFFF;
         13: r = 30'h0001FFFF;
         14: r = 30'h0000FFFF;
         15: r = 30'h00007FFF;
         16: r = 30'h00003FFF;
         17: r = 30'h00001FFF;
         18: r = 30'h00000FFF;
         19: r = 30'h000007FF;
         20: r = 30'h000003FF;
         21: r = 30'h000001FF;
         22: r = 30'h000000FF;
         23: r = 30'h0000007F;
         24: r = 30'h0000003F;
         25: r = 30'h0000001F;
         26: r = 30'h0000000F;
         27: r = 30'h00000007;
         28: r = 30'h00000003;
         29: r = 30'h00000001;
         default: r = '0;
      endcase
      return r;
   endfunction

endpackage

// ----- rtl/qte_if.sv -----
// ----------------------------------------------------------------------------
// qte channel interfaces
// request, response and control register write channels
// ----------------------------------------------------------------------------
interface qte_req_if #(parameter int COMPONENT_WIDTH = 16);
   logic                              valid;
   logic                              ready;
   logic signed [COMPONENT_WIDTH-1:0] quat_real;
   logic signed [COMPONENT_WIDTH-1:0] quat_i;
   logic signed [COMPONENT_WIDTH-1:0] quat_j;
   logic signed [COMPONENT_WIDTH-1:0] quat_k;
   modport source (output valid, quat_real, quat_i, quat_j, quat_k, input ready);
   modport sink   (input valid, quat_real, quat_i, quat_j, quat_k, output ready);
endinterface

interface qte_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] roll_angle;
   logic signed [15:0] pitch_angle;
   logic signed [15:0] yaw_angle;
   logic               pitch_clipped;
   modport source (output valid, roll_angle, pitch_angle, yaw_angle, pitch_clipped,
                   input ready);
   modport sink   (input valid, roll_angle, pitch_angle, yaw_angle, pitch_clipped,
                   output ready);
endinterface

interface qte_csr_if;
   logic valid;
   logic ready;
   logic angle_in_degrees;
   modport source (output valid, angle_in_degrees, input ready);
   modport sink   (input valid, angle_in_degrees, output ready);
endinterface

// ----- rtl/quaternion_to_euler_angles.sv -----
// ----------------------------------------------------------------------------
// quaternion_to_euler_angles
// roll, pitch and yaw from one orientation quaternion per beat
// ----------------------------------------------------------------------------
// req_chan carries one quaternion (real, i, j, k, signed Q1.14) per beat and
// rsp_chan returns roll, pitch, yaw and the pitch clip flag for it, in order.
// csr_chan writes the unit select: 1 gives 1/128 degree, 0 gives 1/8192 rad;
// it is always ready and should only be written with the pipeline empty.
// One beat is accepted every cycle while req_chan.ready is high. A result
// passes through six registers for input, products, sums, operand scaling,
// squares and difference, then 31 square root cells, one setup register,
// the cordic cell chain, two scaling registers and the output register.
// When the receiver stalls, the pipeline keeps moving until its last stage
// holds a result, then all stages freeze and req_chan.ready drops; bubbles
// behind the held result stay where they are until the stall clears.
// Reset empties the pipeline and sets degree units.
// ----------------------------------------------------------------------------
module quaternion_to_euler_angles #(
   parameter int COMPONENT_WIDTH = 16,
   parameter int CORDIC_STAGES   = 16
) (
   input  logic      clock,
   input  logic      reset,
   qte_req_if.sink   req_chan,
   qte_rsp_if.source rsp_chan,
   qte_csr_if.sink   csr_chan
);
   import qte_pkg::*;

   logic advance;
   logic deg_ff;

   // stage 0: normalised components
   logic               v0_ff;
   logic signed [CW-1:0] r0_ff, i0_ff, j0_ff, k0_ff;
   logic signed [CW-1:0] r0_in, i0_in, j0_in, k0_in;

   // stage 1: products
   logic               v1_ff;
   logic signed [31:0] rr_ff, ii_ff, jj_ff, kk_ff;
   logic signed [31:0] jk_ff, ir_ff, ij_ff, kr_ff, jr_ff, ik_ff;

   // stage 2: sums
   logic               v2_ff;
   qte_vec_type        roll2_ff, yaw2_ff;
   logic signed [33:0] num2_ff;
   logic [32:0]        norm2_ff;

   // stage 3: normalised arcsine operands
   logic               v3_ff;
   qte_pass_type       pass3_ff, pass3_in;
   logic [SW-1:0]      nn3_ff, nn3_in;
   logic [33:0]        anum;
   logic [32:0]        nsh, ash;

   // stage 4: squares, stage 5: difference
   logic               v4_ff, v5_ff;
   qte_pass_type       pass4_ff, pass5_ff;
   logic [RW-1:0]      nn2_ff, ss2_ff, diff5_ff;

   // square root chain
   logic               sq_valid [0:SW];
   logic [RW-1:0]      sq_rem   [0:SW];
   logic [SW-1:0]      sq_root  [0:SW];
   qte_pass_type       sq_pass  [0:SW];

   // cordic chains, lane 0 roll, 1 pitch, 2 yaw
   logic               cd_valid [0:2][0:CORDIC_STAGES];
   qte_cord_type       cd_st    [0:2][0:CORDIC_STAGES];
   qte_vec_type        pre_vec  [0:2];
   qte_cord_type       pre_in   [0:2];
   logic               v6_ff;

   // scaling
   logic                 cv1_ff, cv2_ff, last_valid;
   logic                 clip1_ff, clip2_ff;
   logic signed [ZW-1:0] zf [0:2];
   logic signed [15:0]   ang [0:2];

   // output register
   logic               rsp_valid_ff;
   logic signed [15:0] roll_ff, pitch_ff, yaw_ff;
   logic               clip_ff;

   assign last_valid = cv2_ff;
   assign advance    = !(last_valid && rsp_valid_ff && !rsp_chan.ready);
   assign req_chan.ready = advance;
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         deg_ff <= 1'b1;
      end else if (csr_chan.valid) begin
         deg_ff <= csr_chan.angle_in_degrees;
      end
   end

   // component width to 16 bits
   generate
      if (COMPONENT_WIDTH >= CW) begin : g_narrow
         assign r0_in = req_chan.quat_real[COMPONENT_WIDTH-1 -: CW];
         assign i0_in = req_chan.quat_i[COMPONENT_WIDTH-1 -: CW];
         assign j0_in = req_chan.quat_j[COMPONENT_WIDTH-1 -: CW];
         assign k0_in = req_chan.quat_k[COMPONENT_WIDTH-1 -: CW];
      end else begin : g_widen
         assign r0_in = {req_chan.quat_real, {(CW-COMPONENT_WIDTH){1'b0}}};
         assign i0_in = {req_chan.quat_i, {(CW-COMPONENT_WIDTH){1'b0}}};
         assign j0_in = {req_chan.quat_j, {(CW-COMPONENT_WIDTH){1'b0}}};
         assign k0_in = {req_chan.quat_k, {(CW-COMPONENT_WIDTH){1'b0}}};
      end
   endgenerate

   always_comb begin
      anum = num2_ff[33] ? 34'(-num2_ff) : 34'(num2_ff);
      priority if (norm2_ff[32]) begin
         nsh = norm2_ff >> 2;
         ash = anum[32:0] >> 2;
      end else if (norm2_ff[31]) begin
         nsh = norm2_ff >> 1;
         ash = anum[32:0] >> 1;
      end else begin
         nsh = norm2_ff;
         ash = anum[32:0];
      end
      pass3_in.roll     = roll2_ff;
      pass3_in.yaw      = yaw2_ff;
      pass3_in.neg      = num2_ff[33];
      pass3_in.tag.clip = 1'b0;
      pass3_in.tag.mode = PM_ATAN;
      pass3_in.ss       = ash[SW-1:0];
      nn3_in            = nsh[SW-1:0];
      // a zero norm goes through as a zero vector and yields zero
      if (norm2_ff != '0 && 34'(norm2_ff) <= anum) begin
         pass3_in.tag.mode = num2_ff[33] ? PM_NEG : PM_POS;
         pass3_in.tag.clip = 34'(norm2_ff) != anum;
         pass3_in.ss       = '0;
         nn3_in            = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (advance) begin
         v0_ff <= req_chan.valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         r0_ff <= r0_in;
         i0_ff <= i0_in;
         j0_ff <= j0_in;
         k0_ff <= k0_in;

         rr_ff <= r0_ff * r0_ff;
         ii_ff <= i0_ff * i0_ff;
         jj_ff <= j0_ff * j0_ff;
         kk_ff <= k0_ff * k0_ff;
         jk_ff <= j0_ff * k0_ff;
         ir_ff <= i0_ff * r0_ff;
         ij_ff <= i0_ff * j0_ff;
         kr_ff <= k0_ff * r0_ff;
         jr_ff <= j0_ff * r0_ff;
         ik_ff <= i0_ff * k0_ff;

         roll2_ff.y <= XW'((34'(jk_ff) + 34'(ir_ff)) <<< 1);
         roll2_ff.x <= XW'(34'(rr_ff) + 34'(kk_ff) - 34'(ii_ff) - 34'(jj_ff));
         yaw2_ff.y  <= XW'((34'(ij_ff) + 34'(kr_ff)) <<< 1);
         yaw2_ff.x  <= XW'(34'(rr_ff) + 34'(ii_ff) - 34'(jj_ff) - 34'(kk_ff));
         num2_ff    <= (34'(jr_ff) - 34'(ik_ff)) <<< 1;
         norm2_ff   <= 33'(34'(rr_ff) + 34'(ii_ff) + 34'(jj_ff) + 34'(kk_ff));

         pass3_ff <= pass3_in;
         nn3_ff   <= nn3_in;

         pass4_ff <= pass3_ff;
         nn2_ff   <= nn3_ff * nn3_ff;
         ss2_ff   <= pass3_ff.ss * pass3_ff.ss;

         pass5_ff <= pass4_ff;
         diff5_ff <= nn2_ff - ss2_ff;
      end
   end

   assign sq_valid[0] = v5_ff;
   assign sq_rem[0]   = diff5_ff;
   assign sq_root[0]  = '0;
   assign sq_pass[0]  = pass5_ff;

   generate
      for (genvar g = 0; g < SW; g++) begin : g_sqrt
         qte_sqrt_cell #(.BIT(SW - 1 - g)) u_cell (
            .clock     (clock),
            .reset     (reset),
            .enable    (advance),
            .in_valid  (sq_valid[g]),
            .in_rem    (sq_rem[g]),
            .in_root   (sq_root[g]),
            .in_pass   (sq_pass[g]),
            .out_valid (sq_valid[g+1]),
            .out_rem   (sq_rem[g+1]),
            .out_root  (sq_root[g+1]),
            .out_pass  (sq_pass[g+1])
         );
      end
   endgenerate

   // cordic setup: fold the left half plane onto the right
   always_comb begin
      pre_vec[0]   = sq_pass[SW].roll;
      pre_vec[1].x = XW'(sq_root[SW]);
      pre_vec[1].y = sq_pass[SW].neg ? -XW'(sq_pass[SW].ss) : XW'(sq_pass[SW].ss);
      pre_vec[2]   = sq_pass[SW].yaw;
      for (int l = 0; l < 3; l++) begin
         pre_in[l].zero = pre_vec[l].x == '0 && pre_vec[l].y == '0;
         pre_in[l].tag  = (l == 1) ? sq_pass[SW].tag : '0;
         if (pre_vec[l].x[XW-1]) begin
            pre_in[l].z   = pre_vec[l].y[XW-1] ? -ANG_PI : ANG_PI;
            pre_in[l].v.x = -pre_vec[l].x;
            pre_in[l].v.y = -pre_vec[l].y;
         end else begin
            pre_in[l].z   = '0;
            pre_in[l].v   = pre_vec[l];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v6_ff <= 1'b0;
      end else if (advance) begin
         v6_ff <= sq_valid[SW];
      end
   end

   generate
      for (genvar l = 0; l < 3; l++) begin : g_lane
         always_ff @(posedge clock) begin
            if (advance) begin
               cd_st[l][0] <= pre_in[l];
            end
         end
         assign cd_valid[l][0] = v6_ff;
         for (genvar s = 0; s < CORDIC_STAGES; s++) begin : g_stage
            qte_cordic_cell #(.STAGE(s)) u_cell (
               .clock     (clock),
               .reset     (reset),
               .enable    (advance),
               .in_valid  (cd_valid[l][s]),
               .in_st     (cd_st[l][s]),
               .out_valid (cd_valid[l][s+1]),
               .out_st    (cd_st[l][s+1])
            );
         end
      end
   endgenerate

   always_comb begin
      for (int l = 0; l < 3; l++) begin
         zf[l] = cd_st[l][CORDIC_STAGES].zero ? '0 : cd_st[l][CORDIC_STAGES].z;
      end
      unique case (cd_st[1][CORDIC_STAGES].tag.mode)
         PM_POS:  zf[1] = ANG_HALF_PI;
         PM_NEG:  zf[1] = -ANG_HALF_PI;
         PM_ATAN: zf[1] = cd_st[1][CORDIC_STAGES].zero ? '0 : cd_st[1][CORDIC_STAGES].z;
         default: zf[1] = '0;
      endcase
   end

   generate
      for (genvar l = 0; l < 3; l++) begin : g_conv
         qte_angle_conv u_conv (
            .clock  (clock),
            .enable (advance),
            .deg    (deg_ff),
            .z      (zf[l]),
            .angle  (ang[l])
         );
      end
   endgenerate

   always_ff @(posedge clock) begin
      if (reset) begin
         cv1_ff <= 1'b0;
         cv2_ff <= 1'b0;
      end else if (advance) begin
         cv1_ff <= cd_valid[0][CORDIC_STAGES] & cd_valid[1][CORDIC_STAGES]
                   & cd_valid[2][CORDIC_STAGES];
         cv2_ff <= cv1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         clip1_ff <= cd_st[1][CORDIC_STAGES].tag.clip;
         clip2_ff <= clip1_ff;
      end
   end

   // output register; loads whenever it is free or being emptied
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_chan.ready) begin
         rsp_valid_ff <= last_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || rsp_chan.ready) begin
         roll_ff  <= ang[0];
         pitch_ff <= ang[1];
         yaw_ff   <= ang[2];
         clip_ff  <= clip2_ff;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.roll_angle    = roll_ff;
   assign rsp_chan.pitch_angle   = pitch_ff;
   assign rsp_chan.yaw_angle     = yaw_ff;
   assign rsp_chan.pitch_clipped = clip_ff;

endmodule

// ----- rtl/qte_sqrt_cell.sv -----
// ----------------------------------------------------------------------------
// qte_sqrt_cell
// one result bit of a restoring integer square root, registered
// ----------------------------------------------------------------------------
module qte_sqrt_cell #(
   parameter int BIT = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  logic                  in_valid,
   input  logic [qte_pkg::RW-1:0] in_rem,
   input  logic [qte_pkg::SW-1:0] in_root,
   input  qte_pkg::qte_pass_type in_pass,
   output logic                  out_valid,
   output logic [qte_pkg::RW-1:0] out_rem,
   output logic [qte_pkg::SW-1:0] out_root,
   output qte_pkg::qte_pass_type out_pass
);
   import qte_pkg::*;

   logic                valid_ff;
   logic [RW-1:0]       rem_ff, rem_in;
   logic [SW-1:0]       root_ff, root_in;
   qte_pass_type        pass_ff;
   logic [63:0]         trial;
   logic                take;

   // (root + 2^b)^2 - root^2 = root * 2^(b+1) + 2^(2b)
   always_comb begin
      trial   = (64'(in_root) << (BIT + 1)) + (64'd1 << (2 * BIT));
      take    = 64'(in_rem) >= trial;
      rem_in  = take ? in_rem - trial[RW-1:0] : in_rem;
      root_in = take ? (in_root | (SW'(1) << BIT)) : in_root;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rem_ff  <= rem_in;
         root_ff <= root_in;
         pass_ff <= in_pass;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_root  = root_ff;
   assign out_pass  = pass_ff;

endmodule

// ----- rtl/qte_cordic_cell.sv -----
// ----------------------------------------------------------------------------
// qte_cordic_cell
// one vectoring cordic micro-rotation, registered
// ----------------------------------------------------------------------------
module qte_cordic_cell #(
   parameter int STAGE = 0
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  enable,
   input  logic                  in_valid,
   input  qte_pkg::qte_cord_type in_st,
   output logic                  out_valid,
   output qte_pkg::qte_cord_type out_st
);
   import qte_pkg::*;

   logic                 valid_ff;
   qte_cord_type         st_ff, st_in;
   logic signed [XW-1:0] dx, dy;
   logic signed [ZW-1:0] ang;

   always_comb begin
      dx    = in_st.v.y >>> STAGE;
      dy    = in_st.v.x >>> STAGE;
      ang   = $signed(ZW'(atan_entry(STAGE)));
      st_in = in_st;
      if (!in_st.v.y[XW-1]) begin
         st_in.v.x = in_st.v.x + dx;
         st_in.v.y = in_st.v.y - dy;
         st_in.z   = in_st.z + ang;
      end else begin
         st_in.v.x = in_st.v.x - dx;
         st_in.v.y = in_st.v.y + dy;
         st_in.z   = in_st.z - ang;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         st_ff <= st_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_st    = st_ff;

endmodule

// ----- rtl/qte_angle_conv.sv -----
// ----------------------------------------------------------------------------
// qte_angle_conv
// clamps an internal angle to +-pi and scales it to output units
// ----------------------------------------------------------------------------
module qte_angle_conv (
   input  logic                          clock,
   input  logic                          enable,
   input  logic                          deg,
   input  logic signed [qte_pkg::ZW-1:0] z,
   output logic signed [15:0]            angle
);
   import qte_pkg::*;

   logic signed [33:0] zc_ff, zc_in;
   logic signed [48:0] ph_ff;
   logic [46:0]        pl_ff;
   logic signed [15:0] rad_ff;
   logic signed [34:0] rsum;
   logic signed [65:0] dsum;

   always_comb begin
      priority if (z > ANG_PI) begin
         zc_in = 34'(ANG_PI);
      end else if (z < -ANG_PI) begin
         zc_in = 34'(-ANG_PI);
      end else begin
         zc_in = 34'(z);
      end
   end

   // radian rounding; the degree product below is split into high and low halves of the angle
   always_comb begin
      rsum = 35'(zc_ff) + 35'sd65536;
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         zc_ff  <= zc_in;
         ph_ff  <= $signed(zc_ff[32:16]) * $signed({1'b0, DEG_SCALE});
         pl_ff  <= zc_ff[15:0] * DEG_SCALE;
         rad_ff <= rsum[32:17];
      end
   end

   always_comb begin
      dsum  = (66'(ph_ff) <<< 16) + $signed(66'(pl_ff)) + (66'sd1 <<< 47);
      angle = deg ? dsum[63:48] : rad_ff;
   end

endmodule

// ----- rtl/qte_checker.sv -----
// ----------------------------------------------------------------------------
// qte_checker
// port level checks of the quaternion to euler angle block
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module qte_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [15:0] roll_angle,
   input logic signed [15:0] pitch_angle,
   input logic signed [15:0] yaw_angle,
   input logic               pitch_clipped
);

   logic roll_ok, pitch_ok, yaw_ok, pitch_half_ok;

   assign roll_ok       = roll_angle >= -16'sd25736 && roll_angle <= 16'sd25736;
   assign pitch_ok      = pitch_angle >= -16'sd25736 && pitch_angle <= 16'sd25736;
   assign yaw_ok        = yaw_angle >= -16'sd25736 && yaw_angle <= 16'sd25736;
   assign pitch_half_ok = pitch_angle >= -16'sd12868 && pitch_angle <= 16'sd12868;

   // a stalled beat stays offered
   `QTE_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid)

   // angles never leave +-25736, which is +-pi in radian units
   `QTE_ASSERT_IMP(a_range, clock, reset, rsp_valid, roll_ok && pitch_ok && yaw_ok)

   // exact products keep the arcsine argument within one
   `QTE_ASSERT_IMP(a_no_clip, clock, reset, rsp_valid, !pitch_clipped)

   // pitch never beyond a quarter turn either way
   `QTE_ASSERT_IMP(a_pitch_half, clock, reset, rsp_valid, pitch_half_ok)

endmodule

bind quaternion_to_euler_angles qte_checker u_qte_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_chan.valid),
   .rsp_ready     (rsp_chan.ready),
   .roll_angle    (rsp_chan.roll_angle),
   .pitch_angle   (rsp_chan.pitch_angle),
   .yaw_angle     (rsp_chan.yaw_angle),
   .pitch_clipped (rsp_chan.pitch_clipped)
);
